// ===== sv/nfcs_pkg.sv =====
// Shared types and constants for the NAND flash command sequencer.
package nfcs_pkg;

  localparam logic [13:0] MAX_TRANSFER = 14'd8192;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] MODE_READ    = 3'd0;
  localparam logic [2:0] MODE_PROGRAM = 3'd1;
  localparam logic [2:0] MODE_ERASE   = 3'd2;
  localparam logic [2:0] MODE_RESET   = 3'd3;
  localparam logic [2:0] MODE_READY   = 3'd4;
  localparam logic [2:0] MODE_FBYTE   = 3'd5;
  localparam logic [2:0] MODE_PBYTE   = 3'd6;

  localparam logic [2:0] ACT_SELECT  = 3'd0;
  localparam logic [2:0] ACT_CMD     = 3'd1;
  localparam logic [2:0] ACT_ADDR    = 3'd2;
  localparam logic [2:0] ACT_WDATA   = 3'd3;
  localparam logic [2:0] ACT_RDATA   = 3'd4;
  localparam logic [2:0] ACT_STATUS  = 3'd5;
  localparam logic [2:0] ACT_RELEASE = 3'd6;
  localparam logic [2:0] ACT_REJECT  = 3'd7;

  localparam logic [7:0] CMD_READ      = 8'h00;
  localparam logic [7:0] CMD_READ_GO   = 8'h30;
  localparam logic [7:0] CMD_PROG      = 8'h80;
  localparam logic [7:0] CMD_PROG_GO   = 8'h10;
  localparam logic [7:0] CMD_STATUS    = 8'h70;
  localparam logic [7:0] CMD_ERASE     = 8'h60;
  localparam logic [7:0] CMD_ERASE_GO  = 8'hD0;
  localparam logic [7:0] CMD_RESET     = 8'hFF;

  localparam logic [3:0] J_READ      = 4'd0;
  localparam logic [3:0] J_PROG      = 4'd1;
  localparam logic [3:0] J_PROG0     = 4'd2;
  localparam logic [3:0] J_ERASE     = 4'd3;
  localparam logic [3:0] J_RESET     = 4'd4;
  localparam logic [3:0] J_RELEASE   = 4'd5;
  localparam logic [3:0] J_CMD70     = 4'd6;
  localparam logic [3:0] J_RDATA     = 4'd7;
  localparam logic [3:0] J_RDATA_REL = 4'd8;
  localparam logic [3:0] J_STATUS    = 4'd9;
  localparam logic [3:0] J_WDATA     = 4'd10;
  localparam logic [3:0] J_WDATA_10  = 4'd11;
  localparam logic [3:0] J_REJECT    = 4'd12;

  typedef struct packed {
    logic [3:0]  op;
    logic [23:0] row;
    logic [7:0]  data;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } qrd_t;

endpackage

// ===== sv/nand_flash_command_sequencer_unit.sv =====
// Top level of the large-page NAND flash command sequencer.
// The item channel (item_valid, item_stall) takes one word per request or
// flash event: mode, row_address, transfer_size and data_byte.
// The result channel (result_valid, result_stall) gives bus actions as
// action, bus_byte and last, where last marks the final word of one item.
// A read request yields eight words, a program request seven or eight,
// an erase six, a reset two, data and status events one or two, and a
// ready event none or one.
// An accepted item that yields result words enters a four-entry job queue;
// when the back end is idle, it registers the item's first result word.
// Items are taken one per cycle while the queue has room. Unless the receiver
// stalls, results leave one per cycle, so the data phase moves one byte per
// cycle, and the back end sets the sustained rate at one action a cycle.
// Reset empties the queue, drops any pending result and returns to idle.
// When the receiver stalls, the output word holds, the queue fills, and
// item_stall rises once all four entries are taken.
module nand_flash_command_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  mode,
  input  logic [23:0] row_address,
  input  logic [13:0] transfer_size,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  action,
  output logic [7:0]  bus_byte,
  output logic        last
);

  nfcs_pkg::job_t                push_job;
  nfcs_pkg::job_t                head;
  nfcs_pkg::qwr_t                wr_side;
  nfcs_pkg::qrd_t                rd_side;
  logic                          push;
  logic                          pop;
  logic                          mid_burst;
  logic [nfcs_pkg::QCNT_W-1:0]   level;

  nfcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .mode          (mode),
    .row_address   (row_address),
    .transfer_size (transfer_size),
    .data_byte     (data_byte),
    .q_full        (wr_side.full),
    .q_push        (push),
    .q_job         (push_job)
  );

  nfcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_job  (push_job),
    .wr_side (wr_side),
    .pop     (pop),
    .rd_side (rd_side),
    .head    (head),
    .level   (level)
  );

  nfcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (rd_side.empty),
    .q_pop        (pop),
    .mid_burst    (mid_burst),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .action       (action),
    .bus_byte     (bus_byte),
    .last         (last)
  );

`ifndef ASSERT_OFF
  a_level_bound : assert property (@(posedge clk) disable iff (rst)
    level <= nfcs_pkg::QCNT_W'(nfcs_pkg::QUEUE_DEPTH))
    else $error("job queue level exceeds its depth");

  a_burst_has_job : assert property (@(posedge clk) disable iff (rst)
    mid_burst |-> !rd_side.empty)
    else $error("burst in progress without a queued job");

  a_reject_last : assert property (@(posedge clk) disable iff (rst)
    (result_valid && action == nfcs_pkg::ACT_REJECT) |-> last)
    else $error("rejected word not marked last");

  a_push_not_full : assert property (@(posedge clk) disable iff (rst)
    wr_side.push |-> (item_valid && !item_stall))
    else $error("queue written without an accepted word");
`endif

endmodule

// ===== sv/nfcs_front.sv =====
// Front end: accepts words, tracks the flash phase and classifies words into jobs.
module nfcs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [2:0]          mode,
  input  logic [23:0]         row_address,
  input  logic [13:0]         transfer_size,
  input  logic [7:0]          data_byte,
  input  logic                q_full,
  output logic                q_push,
  output nfcs_pkg::job_t      q_job
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RD_WAIT  = 3'd1;
  localparam logic [2:0] PH_RD_DATA  = 3'd2;
  localparam logic [2:0] PH_WR_DATA  = 3'd3;
  localparam logic [2:0] PH_BUSY     = 3'd4;
  localparam logic [2:0] PH_STATUS   = 3'd5;
  localparam logic [2:0] PH_RST_WAIT = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [13:0] bytes_left, bytes_left_next;
  logic [13:0] len;
  logic        accept;
  logic        emit;
  logic [3:0]  op;

  assign item_stall = q_full;
  assign accept     = item_valid & ~q_full;
  assign len = (transfer_size > nfcs_pkg::MAX_TRANSFER) ? nfcs_pkg::MAX_TRANSFER
                                                        : transfer_size;

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    emit            = 1'b1;
    op              = nfcs_pkg::J_REJECT;
    case (mode)
      nfcs_pkg::MODE_READ: begin
        if (phase == PH_IDLE) begin
          op              = nfcs_pkg::J_READ;
          bytes_left_next = len;
          phase_next      = PH_RD_WAIT;
        end
      end
      nfcs_pkg::MODE_PROGRAM: begin
        if (phase == PH_IDLE) begin
          bytes_left_next = len;
          if (len == 14'd0) begin
            op         = nfcs_pkg::J_PROG0;
            phase_next = PH_BUSY;
          end else begin
            op         = nfcs_pkg::J_PROG;
            phase_next = PH_WR_DATA;
          end
        end
      end
      nfcs_pkg::MODE_ERASE: begin
        if (phase == PH_IDLE) begin
          op         = nfcs_pkg::J_ERASE;
          phase_next = PH_BUSY;
        end
      end
      nfcs_pkg::MODE_RESET: begin
        if (phase == PH_IDLE) begin
          op         = nfcs_pkg::J_RESET;
          phase_next = PH_RST_WAIT;
        end
      end
      nfcs_pkg::MODE_READY: begin
        if (phase == PH_RD_WAIT) begin
          if (bytes_left == 14'd0) begin
            op         = nfcs_pkg::J_RELEASE;
            phase_next = PH_IDLE;
          end else begin
            emit       = 1'b0;
            phase_next = PH_RD_DATA;
          end
        end else if (phase == PH_BUSY) begin
          op         = nfcs_pkg::J_CMD70;
          phase_next = PH_STATUS;
        end else if (phase == PH_RST_WAIT) begin
          op         = nfcs_pkg::J_RELEASE;
          phase_next = PH_IDLE;
        end
      end
      nfcs_pkg::MODE_FBYTE: begin
        if (phase == PH_RD_DATA && bytes_left != 14'd0) begin
          bytes_left_next = bytes_left - 14'd1;
          if (bytes_left == 14'd1) begin
            op         = nfcs_pkg::J_RDATA_REL;
            phase_next = PH_IDLE;
          end else begin
            op = nfcs_pkg::J_RDATA;
          end
        end else if (phase == PH_STATUS) begin
          op         = nfcs_pkg::J_STATUS;
          phase_next = PH_IDLE;
        end
      end
      nfcs_pkg::MODE_PBYTE: begin
        if (phase == PH_WR_DATA && bytes_left != 14'd0) begin
          bytes_left_next = bytes_left - 14'd1;
          if (bytes_left == 14'd1) begin
            op         = nfcs_pkg::J_WDATA_10;
            phase_next = PH_BUSY;
          end else begin
            op = nfcs_pkg::J_WDATA;
          end
        end
      end
      default: begin
        op = nfcs_pkg::J_REJECT;
      end
    endcase
    if (emit && op == nfcs_pkg::J_REJECT) begin
      phase_next      = phase;
      bytes_left_next = bytes_left;
    end
  end

  assign q_push   = accept & emit;
  assign q_job.op = op;
  assign q_job.row  = row_address;
  assign q_job.data = data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bytes_left <= 14'd0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ===== sv/nfcs_queue.sv =====
// Short job queue between the front end and the back end.
module nfcs_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  nfcs_pkg::job_t                wr_job,
  output nfcs_pkg::qwr_t                wr_side,
  input  logic                          pop,
  output nfcs_pkg::qrd_t                rd_side,
  output nfcs_pkg::job_t                head,
  output logic [nfcs_pkg::QCNT_W-1:0]   level
);

  nfcs_pkg::job_t mem [nfcs_pkg::QUEUE_DEPTH];
  logic [nfcs_pkg::QPTR_W-1:0] wr_ptr;
  logic [nfcs_pkg::QPTR_W-1:0] rd_ptr;
  logic [nfcs_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign wr_side.full  = (count == nfcs_pkg::QCNT_W'(nfcs_pkg::QUEUE_DEPTH));
  assign wr_side.push  = do_push;
  assign rd_side.empty = (count == '0);
  assign rd_side.pop   = do_pop;
  assign do_push = push & ~wr_side.full;
  assign do_pop  = pop & ~rd_side.empty;
  assign head  = mem[rd_ptr];
  assign level = count;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/nfcs_back.sv =====
// Back end: expands each queued job into bus actions, one word per cycle unless stalled.
module nfcs_back (
  input  logic           clk,
  input  logic           rst,
  input  nfcs_pkg::job_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           mid_burst,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [2:0]     action,
  output logic [7:0]     bus_byte,
  output logic           last
);

  logic [2:0] step;
  logic [2:0] g_act;
  logic [7:0] g_byte;
  logic       g_last;
  logic       adv;
  logic       fire;

  always_comb begin
    g_act  = nfcs_pkg::ACT_REJECT;
    g_byte = 8'h00;
    g_last = 1'b1;
    case (head.op)
      nfcs_pkg::J_READ, nfcs_pkg::J_PROG, nfcs_pkg::J_PROG0: begin
        g_last = 1'b0;
        case (step)
          3'd0: g_act = nfcs_pkg::ACT_SELECT;
          3'd1: begin
            g_act  = nfcs_pkg::ACT_CMD;
            g_byte = (head.op == nfcs_pkg::J_READ) ? nfcs_pkg::CMD_READ
                                                   : nfcs_pkg::CMD_PROG;
          end
          3'd2, 3'd3: g_act = nfcs_pkg::ACT_ADDR;
          3'd4: begin
            g_act  = nfcs_pkg::ACT_ADDR;
            g_byte = head.row[7:0];
          end
          3'd5: begin
            g_act  = nfcs_pkg::ACT_ADDR;
            g_byte = head.row[15:8];
          end
          3'd6: begin
            g_act  = nfcs_pkg::ACT_ADDR;
            g_byte = head.row[23:16];
            g_last = (head.op == nfcs_pkg::J_PROG);
          end
          default: begin
            g_act  = nfcs_pkg::ACT_CMD;
            g_byte = (head.op == nfcs_pkg::J_READ) ? nfcs_pkg::CMD_READ_GO
                                                   : nfcs_pkg::CMD_PROG_GO;
            g_last = 1'b1;
          end
        endcase
      end
      nfcs_pkg::J_ERASE: begin
        g_last = 1'b0;
        case (step)
          3'd0: g_act = nfcs_pkg::ACT_SELECT;
          3'd1: begin
            g_act  = nfcs_pkg::ACT_CMD;
            g_byte = nfcs_pkg::CMD_ERASE;
          end
          3'd2: begin
            g_act  = nfcs_pkg::ACT_ADDR;
            g_byte = head.row[7:0];
          end
          3'd3: begin
            g_act  = nfcs_pkg::ACT_ADDR;
            g_byte = head.row[15:8];
          end
          3'd4: begin
            g_act  = nfcs_pkg::ACT_ADDR;
            g_byte = head.row[23:16];
          end
          default: begin
            g_act  = nfcs_pkg::ACT_CMD;
            g_byte = nfcs_pkg::CMD_ERASE_GO;
            g_last = 1'b1;
          end
        endcase
      end
      nfcs_pkg::J_RESET: begin
        if (step == 3'd0) begin
          g_act  = nfcs_pkg::ACT_SELECT;
          g_last = 1'b0;
        end else begin
          g_act  = nfcs_pkg::ACT_CMD;
          g_byte = nfcs_pkg::CMD_RESET;
        end
      end
      nfcs_pkg::J_RELEASE: g_act = nfcs_pkg::ACT_RELEASE;
      nfcs_pkg::J_CMD70: begin
        g_act  = nfcs_pkg::ACT_CMD;
        g_byte = nfcs_pkg::CMD_STATUS;
      end
      nfcs_pkg::J_RDATA: begin
        g_act  = nfcs_pkg::ACT_RDATA;
        g_byte = head.data;
      end
      nfcs_pkg::J_RDATA_REL, nfcs_pkg::J_STATUS: begin
        if (step == 3'd0) begin
          g_act  = (head.op == nfcs_pkg::J_STATUS) ? nfcs_pkg::ACT_STATUS
                                                   : nfcs_pkg::ACT_RDATA;
          g_byte = head.data;
          g_last = 1'b0;
        end else begin
          g_act = nfcs_pkg::ACT_RELEASE;
        end
      end
      nfcs_pkg::J_WDATA: begin
        g_act  = nfcs_pkg::ACT_WDATA;
        g_byte = head.data;
      end
      nfcs_pkg::J_WDATA_10: begin
        if (step == 3'd0) begin
          g_act  = nfcs_pkg::ACT_WDATA;
          g_byte = head.data;
          g_last = 1'b0;
        end else begin
          g_act  = nfcs_pkg::ACT_CMD;
          g_byte = nfcs_pkg::CMD_PROG_GO;
        end
      end
      default: begin
        g_act  = nfcs_pkg::ACT_REJECT;
        g_byte = 8'h00;
      end
    endcase
  end

  assign adv       = ~result_valid | ~result_stall;
  assign fire      = adv & ~q_empty;
  assign q_pop     = fire & g_last;
  assign mid_burst = (step != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      step         <= 3'd0;
    end else if (adv) begin
      result_valid <= ~q_empty;
      if (fire) begin
        step <= g_last ? 3'd0 : step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      action   <= g_act;
      bus_byte <= g_byte;
      last     <= g_last;
    end
  end

endmodule

// ===== verif/nand_flash_command_sequencer_unit_tb.sv =====
// Self-checking testbench for the NAND flash command sequencer, with a bus action predictor.
module nand_flash_command_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 380;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RD_WAIT, PH_RD_DATA, PH_WR_DATA, PH_BUSY, PH_STATUS, PH_RST_WAIT
  } seq_phase_t;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] bval;
    logic       last;
  } bus_word_t;

  class action_scoreboard;
    seq_phase_t  phase;
    logic [13:0] bytes_left;
    logic [1:0]  op_kind;
    bus_word_t   burst[$];
    bus_word_t   pending[$];
    int          errors;

    function new();
      phase = PH_IDLE;
      bytes_left = '0;
      op_kind = '0;
      errors = 0;
    endfunction

    function bit rejects(logic [2:0] m);
      case (m)
        nfcs_pkg::MODE_READ, nfcs_pkg::MODE_PROGRAM, nfcs_pkg::MODE_ERASE,
        nfcs_pkg::MODE_RESET: return phase != PH_IDLE;
        nfcs_pkg::MODE_READY: return !(phase inside {PH_RD_WAIT, PH_BUSY, PH_RST_WAIT});
        nfcs_pkg::MODE_FBYTE:
          return !((phase == PH_RD_DATA && bytes_left != 0) || phase == PH_STATUS);
        nfcs_pkg::MODE_PBYTE: return !(phase == PH_WR_DATA && bytes_left != 0);
        default: return 1'b1;
      endcase
    endfunction

    function logic [2:0] wanted_mode();
      case (phase)
        PH_RD_DATA, PH_STATUS: return nfcs_pkg::MODE_FBYTE;
        PH_WR_DATA: return nfcs_pkg::MODE_PBYTE;
        default: return nfcs_pkg::MODE_READY;
      endcase
    endfunction

    function void put(logic [2:0] a, logic [7:0] b);
      burst.push_back('{a, b, 1'b0});
    endfunction

    function void put_row(logic [23:0] row);
      put(nfcs_pkg::ACT_ADDR, row[7:0]);
      put(nfcs_pkg::ACT_ADDR, row[15:8]);
      put(nfcs_pkg::ACT_ADDR, row[23:16]);
    endfunction

    function logic [13:0] clamp(logic [13:0] size);
      return (size > nfcs_pkg::MAX_TRANSFER) ? nfcs_pkg::MAX_TRANSFER : size;
    endfunction

    function void note_item(logic [2:0] m, logic [23:0] row, logic [13:0] size,
                            logic [7:0] dbyte);
      bit ok;
      ok = !rejects(m);
      burst.delete();
      if (ok) begin
        case (m)
          nfcs_pkg::MODE_READ: begin
            put(nfcs_pkg::ACT_SELECT, 8'h00);
            put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_READ);
            put(nfcs_pkg::ACT_ADDR, 8'h00);
            put(nfcs_pkg::ACT_ADDR, 8'h00);
            put_row(row);
            put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_READ_GO);
            bytes_left = clamp(size);
            op_kind = 2'd0;
            phase = PH_RD_WAIT;
          end
          nfcs_pkg::MODE_PROGRAM: begin
            put(nfcs_pkg::ACT_SELECT, 8'h00);
            put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_PROG);
            put(nfcs_pkg::ACT_ADDR, 8'h00);
            put(nfcs_pkg::ACT_ADDR, 8'h00);
            put_row(row);
            bytes_left = clamp(size);
            op_kind = 2'd1;
            if (bytes_left == 0) begin
              put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_PROG_GO);
              phase = PH_BUSY;
            end else begin
              phase = PH_WR_DATA;
            end
          end
          nfcs_pkg::MODE_ERASE: begin
            put(nfcs_pkg::ACT_SELECT, 8'h00);
            put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_ERASE);
            put_row(row);
            put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_ERASE_GO);
            op_kind = 2'd2;
            phase = PH_BUSY;
          end
          nfcs_pkg::MODE_RESET: begin
            put(nfcs_pkg::ACT_SELECT, 8'h00);
            put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_RESET);
            op_kind = 2'd3;
            phase = PH_RST_WAIT;
          end
          nfcs_pkg::MODE_READY: begin
            if (phase == PH_RD_WAIT) begin
              if (bytes_left == 0) begin
                put(nfcs_pkg::ACT_RELEASE, 8'h00);
                phase = PH_IDLE;
              end else begin
                phase = PH_RD_DATA;
              end
            end else if (phase == PH_BUSY) begin
              put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_STATUS);
              phase = PH_STATUS;
            end else begin
              put(nfcs_pkg::ACT_RELEASE, 8'h00);
              phase = PH_IDLE;
            end
          end
          nfcs_pkg::MODE_FBYTE: begin
            if (phase == PH_STATUS) begin
              put(nfcs_pkg::ACT_STATUS, dbyte);
              put(nfcs_pkg::ACT_RELEASE, 8'h00);
              phase = PH_IDLE;
            end else begin
              put(nfcs_pkg::ACT_RDATA, dbyte);
              bytes_left = bytes_left - 14'd1;
              if (bytes_left == 0) begin
                put(nfcs_pkg::ACT_RELEASE, 8'h00);
                phase = PH_IDLE;
              end
            end
          end
          default: begin
            put(nfcs_pkg::ACT_WDATA, dbyte);
            bytes_left = bytes_left - 14'd1;
            if (bytes_left == 0) begin
              put(nfcs_pkg::ACT_CMD, nfcs_pkg::CMD_PROG_GO);
              phase = PH_BUSY;
            end
          end
        endcase
      end else begin
        put(nfcs_pkg::ACT_REJECT, 8'h00);
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    function void check_action(logic [2:0] a, logic [7:0] b, logic l);
      bus_word_t exp_word;
      if (pending.size() == 0) begin
        $error("unexpected result word: action %0d bus_byte %0h last %0b", a, b, l);
        errors++;
        return;
      end
      exp_word = pending.pop_front();
      if (a !== exp_word.act) begin
        $error("action mismatch: expected %0d, got %0d", exp_word.act, a);
        errors++;
      end
      if (b !== exp_word.bval) begin
        $error("bus_byte mismatch: expected %0h, got %0h", exp_word.bval, b);
        errors++;
      end
      if (l !== exp_word.last) begin
        $error("last mismatch: expected %0b, got %0b", exp_word.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [2:0]  mode;
  logic [23:0] row_address;
  logic [13:0] transfer_size;
  logic [7:0]  data_byte;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  action;
  logic [7:0]  bus_byte;
  logic        last;

  action_scoreboard sb;
  int items_taken;
  int burst_left;
  int cycle_cnt;

  nand_flash_command_sequencer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .mode          (mode),
    .row_address   (row_address),
    .transfer_size (transfer_size),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .action        (action),
    .bus_byte      (bus_byte),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input logic [2:0] m, input logic [23:0] row,
                           input logic [13:0] size, input logic [7:0] dbyte);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid    <= 1'b1;
    mode          <= m;
    row_address   <= row;
    transfer_size <= size;
    data_byte     <= dbyte;
    do @(posedge clk); while (item_stall);
    sb.note_item(m, row, size, dbyte);
    items_taken++;
  endtask

  task automatic send_event(input logic [2:0] m, input logic [7:0] dbyte);
    send_item(m, 24'($urandom), 14'($urandom_range(0, 16383)), dbyte);
  endtask

  task automatic send_noise();
    logic [2:0] m;
    do m = 3'($urandom_range(0, 7)); while (!sb.rejects(m));
    send_event(m, 8'($urandom));
  endtask

  // Issues a request, then keeps feeding what the flash side would give until the chip is
  // released, with misplaced words mixed in now and then.
  task automatic run_op(input logic [2:0] m, input logic [23:0] row, input logic [13:0] size);
    send_item(m, row, size, 8'($urandom));
    while (sb.phase != PH_IDLE) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      else send_event(sb.wanted_mode(), 8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_action(action, bus_byte, last);
  end

  initial begin
    int style;
    int len;
    int holds_done;
    int hold_at[2];
    hold_at[0] = 60;
    hold_at[1] = 300;
    holds_done = 0;
    result_stall <= 1'b0;
    @(negedge rst);
    forever begin
      style = $urandom_range(0, 3);
      len = $urandom_range(20, 80);
      repeat (len) begin
        @(posedge clk);
        if (holds_done < 2 && items_taken >= hold_at[holds_done]) begin
          result_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          holds_done++;
        end
        case (style)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= 1'($urandom_range(0, 1));
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int start_cnt;
    int pick;
    logic [13:0] size;
    sb = new();
    items_taken = 0;
    burst_left = 0;
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    mode          <= nfcs_pkg::MODE_READ;
    row_address   <= '0;
    transfer_size <= '0;
    data_byte     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(nfcs_pkg::MODE_RESET, 24'h000000, 14'd0, 8'h00);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_item(nfcs_pkg::MODE_READ, 24'hFFFFFF, 14'd0, 8'h00);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_item(nfcs_pkg::MODE_READ, 24'h000000, 14'd2, 8'h00);
    send_item(nfcs_pkg::MODE_READ, 24'hFFFFFF, 14'h3FFF, 8'hFF);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_event(nfcs_pkg::MODE_FBYTE, 8'h00);
    send_event(nfcs_pkg::MODE_FBYTE, 8'hFF);
    send_item(nfcs_pkg::MODE_PROGRAM, 24'h5A3C96, 14'd0, 8'h00);
    send_event(nfcs_pkg::MODE_PBYTE, 8'hFF);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_event(nfcs_pkg::MODE_FBYTE, 8'hC1);
    send_item(nfcs_pkg::MODE_PROGRAM, 24'hA5C369, 14'd2, 8'h00);
    send_event(nfcs_pkg::MODE_PBYTE, 8'hFF);
    send_event(nfcs_pkg::MODE_PBYTE, 8'h00);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_event(nfcs_pkg::MODE_FBYTE, 8'hE0);
    send_item(nfcs_pkg::MODE_ERASE, 24'hFFFFFF, 14'd5, 8'h00);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_event(nfcs_pkg::MODE_FBYTE, 8'h00);
    send_event(MODE_UNUSED, 8'hFF);
    send_event(nfcs_pkg::MODE_READY, 8'h00);
    send_event(nfcs_pkg::MODE_FBYTE, 8'h00);
    send_event(nfcs_pkg::MODE_PBYTE, 8'h00);
    run_op(nfcs_pkg::MODE_READ, 24'h123456, 14'd9);

    start_cnt = items_taken;
    while (items_taken - start_cnt < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        size = ($urandom_range(0, 99) < 80) ? 14'($urandom_range(0, 5))
                                            : 14'($urandom_range(6, 24));
        run_op(3'($urandom_range(0, 3)), 24'($urandom), size);
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
